[hw/rtl/bpmc_pkg.sv]
// Package for the box pair match cost unit: fixed widths, constants,
// register indexes and the structs that travel between pipeline parts.
// Depends on nothing.
`default_nettype none

package bpmc_pkg;

	localparam int IOU_W      = 17;  // Q0.16, one more bit so that 1.0 fits
	localparam int COST_W     = 24;  // Q8.16
	localparam int WEIGHT_W   = 16;  // Q8.8
	localparam int WSUM_W     = 17;
	localparam int FRAC_W     = 16;
	localparam int DIST_Q_W   = 48;  // quotient N * 2^32 / D
	localparam int ROOT_W     = 24;
	localparam int CFG_IDX_W  = 2;

	localparam logic [COST_W-1:0]   COST_MAX     = {COST_W{1'b1}};
	localparam logic [IOU_W-1:0]    IOU_ONE      = 17'h10000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_IOU  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DIST = 2'd1;

	typedef struct packed {
		logic [IOU_W-1:0]  iou;
		logic [COST_W-1:0] dcost;
		logic [COST_W-1:0] space;
		logic              sat;
	} cost_t;

	typedef struct packed {
		logic [IOU_W-1:0] iou;
		logic             sat;
	} dist_side_t;

	typedef struct packed {
		logic [IOU_W-1:0]  iou;
		logic [COST_W-1:0] dcost;
		logic              sat;
	} space_side_t;

endpackage

`default_nettype wire

[hw/rtl/bpmc_if.sv]
// Channel interfaces of the box pair match cost unit: the box pair input
// and the cost output. Depends on bpmc_pkg.
`default_nettype none

interface bpmc_in_if #(parameter int COORD_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] a_x;
	logic [COORD_BITS-1:0] a_y;
	logic [COORD_BITS-1:0] a_width;
	logic [COORD_BITS-1:0] a_height;
	logic [COORD_BITS-1:0] b_x;
	logic [COORD_BITS-1:0] b_y;
	logic [COORD_BITS-1:0] b_width;
	logic [COORD_BITS-1:0] b_height;

	modport source (output valid, a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height,
		input ready);
	modport sink (input valid, a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height,
		output ready);
endinterface

interface bpmc_out_if;
	logic                          valid;
	logic                          ready;
	logic [bpmc_pkg::IOU_W-1:0]    iou_cost;
	logic [bpmc_pkg::COST_W-1:0]   dist_cost;
	logic [bpmc_pkg::COST_W-1:0]   space_cost;
	logic                          cost_saturated;

	modport source (output valid, iou_cost, dist_cost, space_cost, cost_saturated,
		input ready);
	modport sink (input valid, iou_cost, dist_cost, space_cost, cost_saturated,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/bpmc_geom.sv]
// Box geometry front end: overlap, areas, centre distance and the distance
// divisor over four pipeline stages. Depends on nothing but its parameter.
`default_nettype none

module bpmc_geom #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_v,
	input  wire logic [COORD_BITS-1:0]     a_x,
	input  wire logic [COORD_BITS-1:0]     a_y,
	input  wire logic [COORD_BITS-1:0]     a_width,
	input  wire logic [COORD_BITS-1:0]     a_height,
	input  wire logic [COORD_BITS-1:0]     b_x,
	input  wire logic [COORD_BITS-1:0]     b_y,
	input  wire logic [COORD_BITS-1:0]     b_width,
	input  wire logic [COORD_BITS-1:0]     b_height,
	output logic                           out_v,
	output logic                           ovl,
	output logic                           sat,
	output logic [2*COORD_BITS+1:0]        diff,
	output logic [2*COORD_BITS+1:0]        uni,
	output logic [2*COORD_BITS+2:0]        n,
	output logic [2*COORD_BITS+1:0]        d
);

	localparam int C  = COORD_BITS;
	localparam int AW = 2*C+2;
	localparam int NW = 2*C+3;

	logic [C:0] ea_x, eb_x, ea_y, eb_y, hi_x, hi_y;
	logic [C-1:0] lo_x, lo_y;
	logic [C:0] ca_x, cb_x, ca_y, cb_y;
	logic ovl_c;

	logic v_s1, ovl_s1;
	logic [C-1:0] rw_s1, rh_s1;
	logic [C:0] awp_s1, ahp_s1, bwp_s1, bhp_s1, dx_s1, dy_s1, sw_s1, sh_s1;

	logic v_s2, ovl_s2;
	logic [2*C-1:0] inter_s2;
	logic [AW-1:0] a1_s2, a2_s2, dx2_s2, dy2_s2, sw2_s2, sh2_s2;

	logic v_s3, ovl_s3;
	logic [AW-1:0] uni_s3, diff_s3, d_s3;
	logic [NW-1:0] n_s3;

	logic v_s4, ovl_s4, sat_s4;
	logic [AW-1:0] uni_s4, diff_s4, d_s4;
	logic [NW-1:0] n_s4;

	always_comb begin
		ea_x = {1'b0, a_x} + {1'b0, a_width};
		eb_x = {1'b0, b_x} + {1'b0, b_width};
		ea_y = {1'b0, a_y} + {1'b0, a_height};
		eb_y = {1'b0, b_y} + {1'b0, b_height};
		hi_x = (ea_x < eb_x) ? ea_x : eb_x;
		hi_y = (ea_y < eb_y) ? ea_y : eb_y;
		lo_x = (a_x > b_x) ? a_x : b_x;
		lo_y = (a_y > b_y) ? a_y : b_y;
		ovl_c = (hi_x > {1'b0, lo_x}) && (hi_y > {1'b0, lo_y});
		ca_x = {1'b0, a_x} + {2'b0, a_width[C-1:1]};
		cb_x = {1'b0, b_x} + {2'b0, b_width[C-1:1]};
		ca_y = {1'b0, a_y} + {2'b0, a_height[C-1:1]};
		cb_y = {1'b0, b_y} + {2'b0, b_height[C-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// The overlap width never exceeds the narrower box, so it fits C bits.
			ovl_s1 <= ovl_c;
			rw_s1  <= C'(hi_x - {1'b0, lo_x});
			rh_s1  <= C'(hi_y - {1'b0, lo_y});
			awp_s1 <= {1'b0, a_width} + (C+1)'(1);
			ahp_s1 <= {1'b0, a_height} + (C+1)'(1);
			bwp_s1 <= {1'b0, b_width} + (C+1)'(1);
			bhp_s1 <= {1'b0, b_height} + (C+1)'(1);
			dx_s1  <= (ca_x >= cb_x) ? ca_x - cb_x : cb_x - ca_x;
			dy_s1  <= (ca_y >= cb_y) ? ca_y - cb_y : cb_y - ca_y;
			sw_s1  <= {1'b0, a_width} + {1'b0, b_width};
			sh_s1  <= {1'b0, a_height} + {1'b0, b_height};

			ovl_s2   <= ovl_s1;
			inter_s2 <= {{C{1'b0}}, rw_s1} * {{C{1'b0}}, rh_s1};
			a1_s2    <= {{(C+1){1'b0}}, awp_s1} * {{(C+1){1'b0}}, ahp_s1};
			a2_s2    <= {{(C+1){1'b0}}, bwp_s1} * {{(C+1){1'b0}}, bhp_s1};
			dx2_s2   <= {{(C+1){1'b0}}, dx_s1} * {{(C+1){1'b0}}, dx_s1};
			dy2_s2   <= {{(C+1){1'b0}}, dy_s1} * {{(C+1){1'b0}}, dy_s1};
			sw2_s2   <= {{(C+1){1'b0}}, sw_s1} * {{(C+1){1'b0}}, sw_s1};
			sh2_s2   <= {{(C+1){1'b0}}, sh_s1} * {{(C+1){1'b0}}, sh_s1};

			ovl_s3  <= ovl_s2;
			uni_s3  <= a1_s2 + a2_s2 - AW'(inter_s2);
			diff_s3 <= a1_s2 + a2_s2 - (AW'(inter_s2) << 1);
			n_s3    <= NW'(dx2_s2) + NW'(dy2_s2);
			d_s3    <= AW'(sw2_s2 >> 2) + AW'(sh2_s2 >> 2);

			ovl_s4  <= ovl_s3;
			uni_s4  <= uni_s3;
			diff_s4 <= diff_s3;
			n_s4    <= n_s3;
			d_s4    <= d_s3;
			// The distance saturates when the divisor is zero or the ratio reaches 2^16.
			sat_s4  <= (d_s3 == '0) ||
				({{(AW+16-NW){1'b0}}, n_s3} >= {d_s3, 16'b0});
		end
	end

	assign out_v = v_s4;
	assign ovl   = ovl_s4;
	assign sat   = sat_s4;
	assign diff  = diff_s4;
	assign uni   = uni_s4;
	assign n     = n_s4;
	assign d     = d_s4;

endmodule

`default_nettype wire

[hw/rtl/bpmc_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. Depends on nothing but its parameters.
`default_nettype none

module bpmc_div_pipe #(
	parameter int RW = 26,
	parameter int QW = 17,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_v,
	input  wire logic [RW-1:0] rem0,
	input  wire logic [QW-1:0] lo,
	input  wire logic [RW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic               out_v,
	output logic [QW-1:0]      quo,
	output logic [SW-1:0]      side_out
);

	// rem0 must be below den; the bits of lo are shifted in from the top.
	logic          v_s    [QW];
	logic [RW-1:0] rem_s  [QW];
	logic [RW-1:0] den_s  [QW];
	logic [QW-1:0] lo_s   [QW];
	logic [QW-1:0] q_s    [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic          v_p;
		logic [RW-1:0] rem_p, den_p;
		logic [QW-1:0] lo_p, q_p;
		logic [SW-1:0] side_p;
		logic [RW:0]   t, t_sub;
		logic          take;

		if (i == 0) begin : g_first
			assign v_p    = in_v;
			assign rem_p  = rem0;
			assign den_p  = den;
			assign lo_p   = lo;
			assign q_p    = '0;
			assign side_p = side_in;
		end else begin : g_next
			assign v_p    = v_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign den_p  = den_s[i-1];
			assign lo_p   = lo_s[i-1];
			assign q_p    = q_s[i-1];
			assign side_p = side_s[i-1];
		end

		assign t     = {rem_p, lo_p[QW-1]};
		assign take  = t >= {1'b0, den_p};
		assign t_sub = t - {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= take ? t_sub[RW-1:0] : t[RW-1:0];
				den_s[i]  <= den_p;
				lo_s[i]   <= {lo_p[QW-2:0], 1'b0};
				q_s[i]    <= {q_p[QW-2:0], take};
				side_s[i] <= side_p;
			end
		end
	end

	assign out_v    = v_s[QW-1];
	assign quo      = q_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

`default_nettype wire

[hw/rtl/bpmc_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage, with a sideband
// that travels alongside. Depends on nothing but its parameters.
`default_nettype none

module bpmc_sqrt_pipe #(
	parameter int RTW = 24,
	parameter int SW  = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_v,
	input  wire logic [2*RTW-1:0] rad,
	input  wire logic [SW-1:0]    side_in,
	output logic                  out_v,
	output logic [RTW-1:0]        root,
	output logic [SW-1:0]         side_out
);

	logic             v_s    [RTW];
	logic [RTW+1:0]   r_s    [RTW];
	logic [RTW-1:0]   s_s    [RTW];
	logic [2*RTW-1:0] rad_s  [RTW];
	logic [SW-1:0]    side_s [RTW];

	for (genvar i = 0; i < RTW; i++) begin : g_step
		logic             v_p;
		logic [RTW+1:0]   r_p;
		logic [RTW-1:0]   s_p;
		logic [2*RTW-1:0] rad_p;
		logic [SW-1:0]    side_p;
		logic [RTW+3:0]   rr, t, rr_sub;
		logic             take;

		if (i == 0) begin : g_first
			assign v_p    = in_v;
			assign r_p    = '0;
			assign s_p    = '0;
			assign rad_p  = rad;
			assign side_p = side_in;
		end else begin : g_next
			assign v_p    = v_s[i-1];
			assign r_p    = r_s[i-1];
			assign s_p    = s_s[i-1];
			assign rad_p  = rad_s[i-1];
			assign side_p = side_s[i-1];
		end

		// Trial value is four times the partial root plus one.
		assign rr     = {r_p, rad_p[2*RTW-1 -: 2]};
		assign t      = {2'b00, s_p, 2'b01};
		assign take   = rr >= t;
		assign rr_sub = rr - t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i]    <= take ? rr_sub[RTW+1:0] : rr[RTW+1:0];
				s_s[i]    <= {s_p[RTW-2:0], take};
				rad_s[i]  <= {rad_p[2*RTW-3:0], 2'b00};
				side_s[i] <= side_p;
			end
		end
	end

	assign out_v    = v_s[RTW-1];
	assign root     = s_s[RTW-1];
	assign side_out = side_s[RTW-1];

endmodule

`default_nettype wire

[hw/rtl/bpmc_skid.sv]
// Output register with a skid stage that parts the pipeline from the cost
// channel. Depends on bpmc_pkg and bpmc_if.
`default_nettype none

module bpmc_skid (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_v,
	input  wire bpmc_pkg::cost_t din,
	output logic                 en,
	bpmc_out_if.source           cost_out
);

	logic            out_v_q, skid_v_q;
	bpmc_pkg::cost_t out_d_q, skid_d_q;
	logic            push, pop;

	assign en   = !skid_v_q;
	assign push = push_v && en;
	assign pop  = out_v_q && cost_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_d_q <= skid_v_q ? skid_d_q : din;
		end
		if (out_v_q && !pop && push) begin
			skid_d_q <= din;
		end
	end

	assign cost_out.valid          = out_v_q;
	assign cost_out.iou_cost       = out_d_q.iou;
	assign cost_out.dist_cost      = out_d_q.dcost;
	assign cost_out.space_cost     = out_d_q.space;
	assign cost_out.cost_saturated = out_d_q.sat;

endmodule

`default_nettype wire

[hw/rtl/box_pair_match_cost_unit.sv]
// Top level of the box pair match cost unit: weight registers, the divider
// and square root chain, the weighted mean and the output stage.
// Depends on bpmc_pkg, bpmc_if, bpmc_geom, bpmc_div_pipe, bpmc_sqrt_pipe, bpmc_skid.
//
//  channel    direction  handshake      payload
//  pair_in    in         valid/ready    two boxes, corner and size, COORD_BITS each
//  cost_out   out        valid/ready    iou_cost, dist_cost, space_cost, cost_saturated
//  cfg        in         cfg_we         cfg_index, cfg_wdata (weight_iou, weight_dist)
//
// One box pair is accepted in every cycle while the skid stage is not full. The pipeline
// has 4 geometry stages, 17 for the IoU divider, 48 for the distance divider, 24 for the
// square root, 2 for the weighting, 24 for the weighted mean divider and the output
// register. When a result waits and the skid stage is also full, the whole pipeline
// holds. Reset clears the valid bits and sets both weights to 1.0.
`default_nettype none

module box_pair_match_cost_unit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bpmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bpmc_pkg::WEIGHT_W-1:0]      cfg_wdata,
	bpmc_in_if.sink                                 pair_in,
	bpmc_out_if.source                              cost_out
);

	localparam int AW   = 2*COORD_BITS+2;
	localparam int NW   = 2*COORD_BITS+3;
	localparam int ISW  = NW + AW + 2;
	localparam int PIW  = bpmc_pkg::WEIGHT_W + bpmc_pkg::IOU_W;
	localparam int PDW  = bpmc_pkg::WEIGHT_W + bpmc_pkg::COST_W;
	localparam int NUMW = PDW + 1;

	logic [bpmc_pkg::WEIGHT_W-1:0] wi_q, wd_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q <= bpmc_pkg::WEIGHT_RESET;
			wd_q <= bpmc_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bpmc_pkg::REG_WEIGHT_IOU:  wi_q <= cfg_wdata;
				bpmc_pkg::REG_WEIGHT_DIST: wd_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign pair_in.ready = en;

	// Geometry.
	logic g_v, g_ovl, g_sat;
	logic [AW-1:0] g_diff, g_uni, g_d;
	logic [NW-1:0] g_n;

	bpmc_geom #(.COORD_BITS(COORD_BITS)) u_geom (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(pair_in.valid),
		.a_x(pair_in.a_x), .a_y(pair_in.a_y),
		.a_width(pair_in.a_width), .a_height(pair_in.a_height),
		.b_x(pair_in.b_x), .b_y(pair_in.b_y),
		.b_width(pair_in.b_width), .b_height(pair_in.b_height),
		.out_v(g_v), .ovl(g_ovl), .sat(g_sat), .diff(g_diff), .uni(g_uni),
		.n(g_n), .d(g_d)
	);

	// IoU: 17 quotient bits of 2*(U-I)/U, then rounded by halving.
	logic id_v;
	logic [bpmc_pkg::IOU_W-1:0] id_q;
	logic [ISW-1:0] id_side_in, id_side;

	assign id_side_in = {g_ovl, g_sat, g_n, g_d};

	bpmc_div_pipe #(.RW(AW), .QW(bpmc_pkg::IOU_W), .SW(ISW)) u_iou_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(g_v),
		.rem0(g_diff), .lo('0), .den(g_uni), .side_in(id_side_in),
		.out_v(id_v), .quo(id_q), .side_out(id_side)
	);

	logic id_ovl, id_sat;
	logic [NW-1:0] id_n;
	logic [AW-1:0] id_d, dd_rem0;
	logic [bpmc_pkg::IOU_W:0] iou_round;
	bpmc_pkg::dist_side_t dd_side_in, dd_side;
	logic [bpmc_pkg::DIST_Q_W-1:0] dd_lo, dd_q;
	logic dd_v;

	assign id_ovl    = id_side[ISW-1];
	assign id_sat    = id_side[ISW-2];
	assign id_n      = id_side[AW+NW-1:AW];
	assign id_d      = id_side[AW-1:0];
	assign iou_round = ({1'b0, id_q} + (bpmc_pkg::IOU_W+1)'(1)) >> 1;

	assign dd_side_in.iou = id_ovl ? iou_round[bpmc_pkg::IOU_W-1:0] : bpmc_pkg::IOU_ONE;
	assign dd_side_in.sat = id_sat;
	assign dd_rem0 = id_sat ? '0 : AW'(id_n >> bpmc_pkg::FRAC_W);
	assign dd_lo   = {id_n[bpmc_pkg::FRAC_W-1:0], {(2*bpmc_pkg::FRAC_W){1'b0}}};

	// Distance: N * 2^32 / D, then its square root gives Q8.16.
	bpmc_div_pipe #(.RW(AW), .QW(bpmc_pkg::DIST_Q_W),
		.SW($bits(bpmc_pkg::dist_side_t))) u_dist_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(id_v),
		.rem0(dd_rem0), .lo(dd_lo), .den(id_d), .side_in(dd_side_in),
		.out_v(dd_v), .quo(dd_q), .side_out(dd_side)
	);

	logic sq_v;
	logic [bpmc_pkg::ROOT_W-1:0] sq_root;
	bpmc_pkg::dist_side_t sq_side;
	logic [bpmc_pkg::COST_W-1:0] dist_val;

	bpmc_sqrt_pipe #(.RTW(bpmc_pkg::ROOT_W), .SW($bits(bpmc_pkg::dist_side_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(dd_v),
		.rad(dd_q), .side_in(dd_side),
		.out_v(sq_v), .root(sq_root), .side_out(sq_side)
	);

	assign dist_val = sq_side.sat ? bpmc_pkg::COST_MAX : sq_root;

	// Weighting.
	logic v_s1, sat_s1, v_s2, sat_s2;
	logic [PIW-1:0] piou_s1;
	logic [PDW-1:0] pdist_s1;
	logic [bpmc_pkg::IOU_W-1:0] iou_s1, iou_s2;
	logic [bpmc_pkg::COST_W-1:0] dist_s1, dist_s2;
	logic [NUMW-1:0] num_s2;
	logic [bpmc_pkg::WSUM_W-1:0] wsum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= sq_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			piou_s1  <= {{bpmc_pkg::IOU_W{1'b0}}, wi_q} *
				{{bpmc_pkg::WEIGHT_W{1'b0}}, sq_side.iou};
			pdist_s1 <= {{bpmc_pkg::COST_W{1'b0}}, wd_q} *
				{{bpmc_pkg::WEIGHT_W{1'b0}}, dist_val};
			iou_s1   <= sq_side.iou;
			dist_s1  <= dist_val;
			sat_s1   <= sq_side.sat;

			num_s2  <= NUMW'(piou_s1) + NUMW'(pdist_s1);
			wsum_s2 <= {1'b0, wi_q} + {1'b0, wd_q};
			iou_s2  <= iou_s1;
			dist_s2 <= dist_s1;
			sat_s2  <= sat_s1;
		end
	end

	// The weighted mean never exceeds the larger cost, so 24 quotient bits suffice.
	logic wz;
	logic [bpmc_pkg::WSUM_W-1:0] sd_rem0;
	bpmc_pkg::space_side_t sd_side_in, sd_side;
	logic sd_v;
	logic [bpmc_pkg::COST_W-1:0] sd_q;
	bpmc_pkg::cost_t res;

	assign wz      = (wsum_s2 == '0);
	assign sd_rem0 = wz ? '0 : num_s2[NUMW-1:bpmc_pkg::COST_W];
	assign sd_side_in.iou   = iou_s2;
	assign sd_side_in.dcost = dist_s2;
	assign sd_side_in.sat   = sat_s2 || wz;

	bpmc_div_pipe #(.RW(bpmc_pkg::WSUM_W), .QW(bpmc_pkg::COST_W),
		.SW($bits(bpmc_pkg::space_side_t))) u_space_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s2),
		.rem0(sd_rem0), .lo(num_s2[bpmc_pkg::COST_W-1:0]), .den(wsum_s2),
		.side_in(sd_side_in),
		.out_v(sd_v), .quo(sd_q), .side_out(sd_side)
	);

	// With a zero weight sum every trial subtraction succeeds, so the quotient
	// comes out as all ones, which is the saturated cost.
	assign res.iou   = sd_side.iou;
	assign res.dcost = sd_side.dcost;
	assign res.space = sd_q;
	assign res.sat   = sd_side.sat;

	bpmc_skid u_skid (
		.clk(clk), .arst_n(arst_n), .push_v(sd_v), .din(res), .en(en),
		.cost_out(cost_out)
	);

endmodule

`default_nettype wire
